// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the aim tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SWAT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker assertion failed");

// Next-cycle implication, disabled while in reset.
`define SWAT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker assertion failed");

`endif

// ===== rtl/swat_pkg.sv =====
// Types and constants of the step-and-wait aim tracker.
`default_nettype none
package swat_pkg;

   localparam int MAX_SAMPLES      = 1023;
   localparam int MIN_IDLE_SAMPLES = 5;

   localparam int ANGLE_W   = 16;
   localparam int POS_W     = 15;
   localparam int TIME_W    = 32;
   localparam int WIN_W     = 16;
   localparam int TALLY_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W     = ANGLE_W + TALLY_W;
   localparam int CNT_W     = $clog2(SUM_W);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [1:0] {
      REQ_SAMPLE  = 2'd0,
      REQ_ENABLE  = 2'd1,
      REQ_DISABLE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_STEPPING = 2'd1,
      MODE_LOCKED   = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE      = 3'd0,
      CSR_SETTLE_TIME    = 3'd1,
      CSR_DISCARD_TIME   = 3'd2,
      CSR_DEADZONE       = 3'd3,
      CSR_POS_MIN        = 3'd4,
      CSR_POS_MAX        = 3'd5,
      CSR_INVERT         = 3'd6,
      CSR_START_POSITION = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [ANGLE_W-1:0] angle;
      logic [TIME_W-1:0]         time_ms;
   } req_item_type;

   typedef struct packed {
      logic [POS_W-1:0]          position;
      logic [1:0]                track_mode;
      logic                      active;
      logic                      stepped;
      logic signed [ANGLE_W-1:0] last_average;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== rtl/swat_div.sv =====
// Bit-serial signed-by-unsigned divider, truncating toward zero.
`default_nettype none
module swat_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [swat_pkg::SUM_W-1:0]   dividend,
   input  wire logic [swat_pkg::TALLY_W-1:0]        divisor,
   output logic                                     done,
   output logic signed [swat_pkg::ANGLE_W-1:0]      quotient
);

   localparam logic [swat_pkg::CNT_W-1:0] CNT_LAST = swat_pkg::CNT_W'(swat_pkg::SUM_W - 1);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           neg_ff, neg_in;
   logic [swat_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [swat_pkg::TALLY_W-1:0]   rem_ff, rem_in;
   logic [swat_pkg::SUM_W-1:0]     quo_ff, quo_in;
   logic [swat_pkg::TALLY_W-1:0]   dsr_ff, dsr_in;
   logic [swat_pkg::TALLY_W+1:0]   trial;
   logic [swat_pkg::ANGLE_W-1:0]   quo_low;

   // shift one dividend bit into the remainder and try the subtract
   assign trial = {1'b0, rem_ff, quo_ff[swat_pkg::SUM_W-1]} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[swat_pkg::SUM_W-1];
         quo_in  = dividend[swat_pkg::SUM_W-1] ? -dividend : dividend;
         rem_in  = '0;
         cnt_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[swat_pkg::TALLY_W+1]) begin
            rem_in = trial[swat_pkg::TALLY_W-1:0];
         end else begin
            rem_in = {rem_ff[swat_pkg::TALLY_W-2:0], quo_ff[swat_pkg::SUM_W-1]};
         end
         quo_in = {quo_ff[swat_pkg::SUM_W-2:0], ~trial[swat_pkg::TALLY_W+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quo_low  = quo_ff[swat_pkg::ANGLE_W-1:0];
   assign quotient = neg_ff ? -quo_low : quo_low;
   assign done     = done_ff;

   `include "assert_macros.svh"

   `SWAT_ASSERT_IMP(a_start_when_free, clock, reset, start, !busy_ff)
   `SWAT_ASSERT_NXT(a_done_ends_busy, clock, reset, busy_ff && cnt_ff == CNT_LAST, done && !busy_ff)

endmodule
`default_nettype wire

// ===== rtl/step_and_wait_aim_tracker.sv =====
// Step-and-wait aim tracker: one request in, one result out, serial divider for averages.
// Enable, disable, an unused code or an inactive sample skips straight to the result state; a
// sample that takes no average first passes the window checks; each average runs in the
// bit-serial divider (one quotient bit a cycle over the 26-bit sum), at most two per request.
// One request at a time; the next is taken once the result is in the output register.
// Synchronous active-high reset loads the register defaults, servo center and idle mode.
`default_nettype none
module step_and_wait_aim_tracker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire swat_pkg::req_item_type               req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output swat_pkg::rsp_item_type                    rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [swat_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [swat_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   typedef enum logic [5:0] {
      S_WAIT  = 6'b000001,
      S_RUN   = 6'b000010,
      S_CHECK = 6'b000100,
      S_DIV   = 6'b001000,
      S_JUDGE = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   localparam int P = swat_pkg::POS_W;
   localparam int A = swat_pkg::ANGLE_W;

   state_type                          state_ff, state_in;
   // configuration
   logic [P-1:0]                       step_ff, step_in;
   logic [swat_pkg::WIN_W-1:0]         settle_ff, settle_in;
   logic [swat_pkg::WIN_W-1:0]         discard_ff, discard_in;
   logic [P-1:0]                       dead_ff, dead_in;
   logic [P-1:0]                       pmin_ff, pmin_in;
   logic [P-1:0]                       pmax_ff, pmax_in;
   logic                               invert_ff, invert_in;
   logic [P-1:0]                       start_ff, start_in;
   // tracker state
   logic                               active_ff, active_in;
   swat_pkg::mode_type                 mode_ff, mode_in;
   logic [swat_pkg::TIME_W-1:0]        ws_ff, ws_in;
   logic signed [swat_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [swat_pkg::TALLY_W-1:0]       tally_ff, tally_in;
   logic signed [A-1:0]                avg_ff, avg_in;
   logic [P-1:0]                       pos_ff, pos_in;
   // per-request
   swat_pkg::req_item_type             req_ff, req_in;
   logic [swat_pkg::TIME_W-1:0]        elapsed_ff, elapsed_in;
   logic                               stepped_ff, stepped_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   swat_pkg::rsp_item_type             rsp_data_ff, rsp_data_in;

   logic                               lt_discard, lt_settle, on_target, step_up;
   logic [A:0]                         avg_mag;
   logic signed [P+1:0]                pos_next;
   logic [P-1:0]                       pos_clamped;
   logic                               div_start, div_done;
   logic signed [A-1:0]                div_quotient;

   swat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (tally_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign lt_discard = elapsed_ff < {{(swat_pkg::TIME_W-swat_pkg::WIN_W){1'b0}}, discard_ff};
   assign lt_settle  = elapsed_ff < {{(swat_pkg::TIME_W-swat_pkg::WIN_W){1'b0}}, settle_ff};
   assign avg_mag    = avg_ff[A-1] ? -{avg_ff[A-1], avg_ff} : {avg_ff[A-1], avg_ff};
   assign on_target  = avg_mag <= {{(A+1-P){1'b0}}, dead_ff};

   // one step toward the target, then clamp; pos_min wins over pos_max
   assign step_up  = (avg_ff > 0) ^ invert_ff;
   assign pos_next = step_up ? $signed({2'b00, pos_ff}) + $signed({2'b00, step_ff})
                             : $signed({2'b00, pos_ff}) - $signed({2'b00, step_ff});
   always_comb begin
      if (pos_next < $signed({2'b00, pmin_ff})) begin
         pos_clamped = pmin_ff;
      end else if (pos_next > $signed({2'b00, pmax_ff})) begin
         pos_clamped = pmax_ff;
      end else begin
         pos_clamped = pos_next[P-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      settle_in    = settle_ff;
      discard_in   = discard_ff;
      dead_in      = dead_ff;
      pmin_in      = pmin_ff;
      pmax_in      = pmax_ff;
      invert_in    = invert_ff;
      start_in     = start_ff;
      active_in    = active_ff;
      mode_in      = mode_ff;
      ws_in        = ws_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      avg_in       = avg_ff;
      pos_in       = pos_ff;
      req_in       = req_ff;
      elapsed_in   = elapsed_ff;
      stepped_in   = stepped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;

      if (csr_we) begin
         case (csr_index)
            swat_pkg::CSR_STEP_SIZE:      step_in    = csr_wdata[P-1:0];
            swat_pkg::CSR_SETTLE_TIME:    settle_in  = csr_wdata[swat_pkg::WIN_W-1:0];
            swat_pkg::CSR_DISCARD_TIME:   discard_in = csr_wdata[swat_pkg::WIN_W-1:0];
            swat_pkg::CSR_DEADZONE:       dead_in    = csr_wdata[P-1:0];
            swat_pkg::CSR_POS_MIN:        pmin_in    = csr_wdata[P-1:0];
            swat_pkg::CSR_POS_MAX:        pmax_in    = csr_wdata[P-1:0];
            swat_pkg::CSR_INVERT:         invert_in  = csr_wdata[0];
            swat_pkg::CSR_START_POSITION: start_in   = csr_wdata[P-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_WAIT: begin
            if (req_valid) begin
               req_in     = req_data;
               elapsed_in = req_data.time_ms - ws_ff;
               stepped_in = 1'b0;
               state_in   = S_FIN;
               case (req_data.req_type)
                  swat_pkg::REQ_ENABLE: begin
                     active_in = 1'b1;
                     mode_in   = swat_pkg::MODE_IDLE;
                     ws_in     = req_data.time_ms;
                     sum_in    = '0;
                     tally_in  = '0;
                     avg_in    = '0;
                     pos_in    = start_ff;
                  end
                  swat_pkg::REQ_DISABLE: begin
                     active_in = 1'b0;
                     mode_in   = swat_pkg::MODE_IDLE;
                  end
                  swat_pkg::REQ_SAMPLE: begin
                     if (active_ff) begin
                        state_in = S_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RUN: begin
            // accumulate unless tally is full; if stepping, only past discard inside settle
            if (mode_ff != swat_pkg::MODE_STEPPING || (!lt_discard && lt_settle)) begin
               if (tally_ff != swat_pkg::TALLY_W'(swat_pkg::MAX_SAMPLES)) begin
                  sum_in   = sum_ff + swat_pkg::SUM_W'(req_ff.angle);
                  tally_in = tally_ff + 1'b1;
               end
            end
            case (mode_ff)
               swat_pkg::MODE_STEPPING: begin
                  // discard window has priority over the settle window
                  if (lt_discard || lt_settle) begin
                     state_in = S_FIN;
                  end else if (tally_ff != '0) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end else begin
                     state_in = S_JUDGE;
                  end
               end
               swat_pkg::MODE_LOCKED, swat_pkg::MODE_IDLE: begin
                  state_in = S_CHECK;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_CHECK: begin
            state_in = S_FIN;
            case (mode_ff)
               swat_pkg::MODE_LOCKED: begin
                  if (!lt_settle && tally_ff != '0) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               swat_pkg::MODE_IDLE: begin
                  if (!lt_settle &&
                      tally_ff >= swat_pkg::TALLY_W'(swat_pkg::MIN_IDLE_SAMPLES)) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               avg_in   = div_quotient;
               sum_in   = '0;
               tally_in = '0;
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            state_in = S_FIN;
            case (mode_ff)
               swat_pkg::MODE_STEPPING: begin
                  // window closed: the same sample goes on in the new mode
                  sum_in   = '0;
                  tally_in = '0;
                  mode_in  = on_target ? swat_pkg::MODE_LOCKED : swat_pkg::MODE_IDLE;
                  state_in = S_RUN;
               end
               swat_pkg::MODE_LOCKED: begin
                  ws_in = req_ff.time_ms;
                  if (!on_target) begin
                     mode_in  = swat_pkg::MODE_IDLE;
                     state_in = S_RUN;
                  end
               end
               swat_pkg::MODE_IDLE: begin
                  ws_in = req_ff.time_ms;
                  if (on_target) begin
                     mode_in = swat_pkg::MODE_LOCKED;
                  end else begin
                     pos_in     = pos_clamped;
                     mode_in    = swat_pkg::MODE_STEPPING;
                     stepped_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.position     = pos_ff;
               rsp_data_in.track_mode   = mode_ff;
               rsp_data_in.active       = active_ff;
               rsp_data_in.stepped      = stepped_ff;
               rsp_data_in.last_average = avg_ff;
               state_in                 = S_WAIT;
            end
         end
         default: state_in = S_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WAIT;
         step_ff      <= P'(200);
         settle_ff    <= swat_pkg::WIN_W'(500);
         discard_ff   <= swat_pkg::WIN_W'(200);
         dead_ff      <= P'(300);
         pmin_ff      <= '0;
         pmax_ff      <= P'(18000);
         invert_ff    <= 1'b0;
         start_ff     <= P'(9000);
         active_ff    <= 1'b0;
         mode_ff      <= swat_pkg::MODE_IDLE;
         ws_ff        <= '0;
         sum_ff       <= '0;
         tally_ff     <= '0;
         avg_ff       <= '0;
         pos_ff       <= P'(9000);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         settle_ff    <= settle_in;
         discard_ff   <= discard_in;
         dead_ff      <= dead_in;
         pmin_ff      <= pmin_in;
         pmax_ff      <= pmax_in;
         invert_ff    <= invert_in;
         start_ff     <= start_in;
         active_ff    <= active_in;
         mode_ff      <= mode_in;
         ws_ff        <= ws_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         avg_ff       <= avg_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      elapsed_ff  <= elapsed_in;
      stepped_ff  <= stepped_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_WAIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `include "assert_macros.svh"

   `SWAT_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV)
   `SWAT_ASSERT_IMP(a_tally_bounded, clock, reset, 1'b1, tally_ff <= swat_pkg::TALLY_W'(swat_pkg::MAX_SAMPLES))
   `SWAT_ASSERT_IMP(a_run_only_active, clock, reset, state_ff == S_RUN, active_ff)
   `SWAT_ASSERT_IMP(a_step_sets_mode, clock, reset, state_ff == S_FIN && stepped_ff, mode_ff == swat_pkg::MODE_STEPPING)

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the step-and-wait aim tracker: directed table, then random phases.
`default_nettype none
module tb;
   import swat_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam rsp_item_type NO_RSP = '0;

   typedef struct packed {
      req_item_type req;
      logic         typed;
      rsp_item_type rsp;
   } probe_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_item_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // expectation override for table rows, travels with the request
   logic         row_typed = 1'b0;
   rsp_item_type row_rsp = '0;

   rsp_item_type due_results [$];
   int           fails = 0;
   bit           calm = 1'b0;
   int           stall_left = 0;

   // tracker configuration, reset values
   int          cfg_step = 200;
   logic [31:0] cfg_settle = 500;
   logic [31:0] cfg_discard = 200;
   int          cfg_deadzone = 300;
   int          cfg_pos_min = 0;
   int          cfg_pos_max = 18000;
   bit          cfg_invert = 1'b0;
   int          cfg_start = 9000;

   // tracker state
   bit          trk_active = 1'b0;
   mode_type    trk_mode = MODE_IDLE;
   logic [31:0] trk_win_start = '0;
   longint      trk_sum = 0;
   int          trk_tally = 0;
   int          trk_avg = 0;
   int          trk_pos = 9000;

   // walks idle -> step -> stepping -> idle -> lock -> drop out, then wrap and truncation
   probe_row_type probes [25] = '{
      '{'{REQ_SAMPLE, 16'sd5000, 32'd0}, 1'b1, '{15'd9000, MODE_IDLE, 1'b0, 1'b0, 16'sd0}},
      '{'{REQ_UNUSED, 16'hFFFF, 32'hFFFFFFFF}, 1'b1,
        '{15'd9000, MODE_IDLE, 1'b0, 1'b0, 16'sd0}},
      '{'{REQ_DISABLE, 16'sd0, 32'd7}, 1'b1, '{15'd9000, MODE_IDLE, 1'b0, 1'b0, 16'sd0}},
      '{'{REQ_ENABLE, 16'sd0, 32'd1000}, 1'b1, '{15'd9000, MODE_IDLE, 1'b1, 1'b0, 16'sd0}},
      '{'{REQ_SAMPLE, 16'sd1000, 32'd1100}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd1000, 32'd1200}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd1000, 32'd1300}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd1000, 32'd1400}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd1000, 32'd1500}, 1'b1,
        '{15'd9200, MODE_STEPPING, 1'b1, 1'b1, 16'sd1000}},
      '{'{REQ_SAMPLE, 16'h7FFF, 32'd1600}, 1'b1,
        '{15'd9200, MODE_STEPPING, 1'b1, 1'b0, 16'sd1000}},
      '{'{REQ_SAMPLE, 16'h8000, 32'd1800}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd100, 32'd2000}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd100, 32'd2100}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd100, 32'd2200}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd100, 32'd2300}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd100, 32'd2400}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd0, 32'd2900}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, 16'sd5000, 32'd3400}, 1'b0, NO_RSP},
      '{'{REQ_DISABLE, 16'sd0, 32'd3500}, 1'b1,
        '{15'd9200, MODE_IDLE, 1'b0, 1'b0, 16'sd5000}},
      '{'{REQ_ENABLE, 16'sd0, 32'hFFFFFF00}, 1'b1,
        '{15'd9000, MODE_IDLE, 1'b1, 1'b0, 16'sd0}},
      '{'{REQ_SAMPLE, -16'sd301, 32'h00000100}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, -16'sd400, 32'h00000101}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, -16'sd400, 32'h00000102}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, -16'sd400, 32'h00000103}, 1'b0, NO_RSP},
      '{'{REQ_SAMPLE, -16'sd400, 32'h00000104}, 1'b0, NO_RSP}
   };

   step_and_wait_aim_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #12_000_000;
      $display("[step_and_wait_aim_tracker] ERROR");
      $finish;
   end

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic void add_bearing(input int a);
      if (trk_tally < MAX_SAMPLES) begin
         trk_sum += a;
         trk_tally++;
      end
   endfunction

   // truncates toward zero, same as integer division
   function automatic void settle_average();
      trk_avg = int'(trk_sum / trk_tally);
      trk_sum = 0;
      trk_tally = 0;
   endfunction

   function automatic bit within_deadzone();
      int m;
      m = (trk_avg < 0) ? -trk_avg : trk_avg;
      return m <= cfg_deadzone;
   endfunction

   task automatic track_step(input req_item_type r, output rsp_item_type o);
      int          a;
      logic [31:0] elapsed;
      bit          go;
      bit          moved;
      bit          up;
      int          p;
      a = r.angle;
      elapsed = r.time_ms - trk_win_start;
      go = 1'b1;
      moved = 1'b0;
      if (r.req_type == REQ_ENABLE) begin
         trk_active = 1'b1;
         trk_mode = MODE_IDLE;
         trk_win_start = r.time_ms;
         trk_sum = 0;
         trk_tally = 0;
         trk_avg = 0;
         trk_pos = cfg_start;
      end else if (r.req_type == REQ_DISABLE) begin
         trk_active = 1'b0;
         trk_mode = MODE_IDLE;
      end else if (r.req_type == REQ_SAMPLE && trk_active) begin
         if (trk_mode == MODE_STEPPING) begin
            if (elapsed < cfg_discard) begin
               go = 1'b0;
            end else if (elapsed < cfg_settle) begin
               add_bearing(a);
               go = 1'b0;
            end else begin
               if (trk_tally > 0) settle_average();
               trk_sum = 0;
               trk_tally = 0;
               if (within_deadzone()) trk_mode = MODE_LOCKED;
               else trk_mode = MODE_IDLE;
            end
         end
         if (go && trk_mode == MODE_LOCKED) begin
            add_bearing(a);
            if (elapsed >= cfg_settle && trk_tally > 0) begin
               settle_average();
               trk_win_start = r.time_ms;
               if (!within_deadzone()) trk_mode = MODE_IDLE;
            end
         end
         // a drop out of lock is judged again here with the same elapsed time
         if (go && trk_mode == MODE_IDLE) begin
            add_bearing(a);
            if (elapsed >= cfg_settle && trk_tally >= MIN_IDLE_SAMPLES) begin
               settle_average();
               if (within_deadzone()) begin
                  trk_mode = MODE_LOCKED;
                  trk_win_start = r.time_ms;
               end else begin
                  up = (trk_avg > 0) ^ cfg_invert;
                  p = up ? trk_pos + cfg_step : trk_pos - cfg_step;
                  if (p < cfg_pos_min) p = cfg_pos_min;
                  else if (p > cfg_pos_max) p = cfg_pos_max;
                  trk_pos = p;
                  trk_mode = MODE_STEPPING;
                  trk_win_start = r.time_ms;
                  moved = 1'b1;
               end
            end
         end
      end
      o.position = trk_pos[14:0];
      o.track_mode = trk_mode;
      o.active = trk_active;
      o.stepped = moved;
      o.last_average = trk_avg[15:0];
   endtask

   task automatic send_request(input req_item_type r, input logic typed,
                               input rsp_item_type known);
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      row_typed <= typed;
      row_rsp <= known;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_results();
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   task automatic write_config(input logic [15:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= i[CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
         case (csr_index_type'(i))
            CSR_STEP_SIZE:      cfg_step = vals[i][14:0];
            CSR_SETTLE_TIME:    cfg_settle = vals[i];
            CSR_DISCARD_TIME:   cfg_discard = vals[i];
            CSR_DEADZONE:       cfg_deadzone = vals[i][14:0];
            CSR_POS_MIN:        cfg_pos_min = vals[i][14:0];
            CSR_POS_MAX:        cfg_pos_max = vals[i][14:0];
            CSR_INVERT:         cfg_invert = vals[i][0];
            CSR_START_POSITION: cfg_start = vals[i][14:0];
            default: ;
         endcase
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 2) == 0) stall_left <= idle_len();
      end
   end

   always @(posedge clock) begin
      rsp_item_type pred;
      rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            track_step(req_data, pred);
            due_results.push_back(row_typed ? row_rsp : pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result with no request outstanding");
               fails++;
            end else begin
               want = due_results.pop_front();
               if (rsp_data.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_data.position);
                  fails++;
               end
               if (rsp_data.track_mode !== want.track_mode) begin
                  $error("track_mode: expected %0d, got %0d",
                         want.track_mode, rsp_data.track_mode);
                  fails++;
               end
               if (rsp_data.active !== want.active) begin
                  $error("active: expected %0d, got %0d", want.active, rsp_data.active);
                  fails++;
               end
               if (rsp_data.stepped !== want.stepped) begin
                  $error("stepped: expected %0d, got %0d", want.stepped, rsp_data.stepped);
                  fails++;
               end
               if (rsp_data.last_average !== want.last_average) begin
                  $error("last_average: expected %0d, got %0d",
                         want.last_average, rsp_data.last_average);
                  fails++;
               end
            end
         end
      end
   end

   initial begin
      req_item_type r;
      logic [15:0]  vals [8];
      logic [31:0]  now;
      int unsigned  dt_max;
      int           counted;
      int           n;
      int           roll;
      int           bias;
      int           dz;
      int           kind;
      bit           on;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) send_request(probes[i].req, probes[i].typed, probes[i].rsp);
      req_valid <= 1'b0;
      wait_results();

      counted = 0;
      kind = 0;
      while (counted < 1550) begin
         calm = ($urandom_range(0, 3) == 0);
         vals[CSR_STEP_SIZE] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18000)
                                                            : $urandom_range(1, 500);
         vals[CSR_SETTLE_TIME] = $urandom_range(0, 1000);
         vals[CSR_DISCARD_TIME] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1500)
                                                              : $urandom_range(0, vals[1]);
         vals[CSR_DEADZONE] = $urandom_range(0, 2000);
         vals[CSR_POS_MIN] = $urandom_range(0, 9000);
         vals[CSR_POS_MAX] = $urandom_range(9000, 18000);
         vals[CSR_INVERT] = $urandom_range(0, 1);
         vals[CSR_START_POSITION] = $urandom_range(0, 18000);
         case (kind)
            0: foreach (vals[i]) vals[i] = '0;
            1: begin
               foreach (vals[i]) vals[i] = 16'h7FFF;
               vals[CSR_SETTLE_TIME] = 16'hFFFF;
               vals[CSR_DISCARD_TIME] = 16'hFFFF;
               vals[CSR_INVERT] = 16'd1;
            end
            2: begin
               // long window so the tally runs into its ceiling
               vals[CSR_SETTLE_TIME] = 16'hFFFF;
               vals[CSR_DISCARD_TIME] = $urandom_range(0, 16'hFFFF);
               vals[CSR_POS_MIN] = '0;
               vals[CSR_POS_MAX] = 16'd18000;
            end
            3: begin
               vals[CSR_POS_MIN] = $urandom_range(12000, 18000);
               vals[CSR_POS_MAX] = $urandom_range(0, 6000);
            end
            default:
               if ($urandom_range(0, 7) == 0) vals[$urandom_range(0, 7)] = 16'($urandom);
         endcase
         write_config(vals);

         n = (kind == 2) ? 1036 : $urandom_range(40, 100);
         dt_max = vals[CSR_SETTLE_TIME] / 3 + 2;
         dz = vals[CSR_DEADZONE][14:0];
         if (dz > 18000) dz = 18000;
         now = $urandom;
         bias = 0;
         on = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (kind == 2) begin
               r.req_type = REQ_SAMPLE;
               case ($urandom_range(0, 2))
                  0: r.angle = 16'h7FFF;
                  1: r.angle = 16'h8000;
                  default: r.angle = 16'($urandom);
               endcase
               r.time_ms = (i < 1031) ? now + (i % 4) : now + 70000 + i;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 3) r.req_type = REQ_ENABLE;
               else if (roll < 5) r.req_type = REQ_DISABLE;
               else if (roll < 6) r.req_type = REQ_UNUSED;
               else r.req_type = REQ_SAMPLE;
               if ($urandom_range(0, 7) == 0) begin
                  if ($urandom_range(0, 1)) begin
                     bias = $urandom_range(0, dz);
                     if ($urandom_range(0, 1)) bias = -bias;
                  end else begin
                     bias = int'($urandom_range(0, 36000)) - 18000;
                  end
               end
               if ($urandom_range(0, 9) == 0) r.angle = 16'($urandom);
               else r.angle = 16'(bias + $urandom_range(0, 100) - 50);
               if ($urandom_range(0, 29) == 0) now = now + $urandom;
               else now = now + $urandom_range(0, dt_max);
               r.time_ms = now;
            end
            if (i == 0) r.req_type = REQ_ENABLE;
            if (r.req_type == REQ_ENABLE) on = 1'b1;
            if (r.req_type == REQ_DISABLE) on = 1'b0;
            if (r.req_type == REQ_ENABLE || r.req_type == REQ_DISABLE ||
                (r.req_type == REQ_SAMPLE && on)) counted++;
            send_request(r, 1'b0, NO_RSP);
         end
         req_valid <= 1'b0;
         wait_results();
         kind++;
      end

      repeat (64) @(posedge clock);
      if (fails == 0) $display("[step_and_wait_aim_tracker] OK");
      else $display("[step_and_wait_aim_tracker] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
